@@ design/assert_macros.svh @@
// Assertion macros for the core, the one design file that carries checks.
// No dependencies; the enclosing module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RTU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RTU_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RTU_ASSERT(label, prop, msg)
`define RTU_ASSERT_NEVER(label, cond, msg)
`endif
`endif

@@ design/rtuslv_pkg.sv @@
// Types, constants and the CRC-16 byte update for the Modbus RTU register slave.
// No dependencies; used by every module of the block.
package rtuslv_pkg;

    localparam logic [7:0] FN_READ      = 8'h03;
    localparam logic [7:0] FN_WRITE     = 8'h06;
    localparam logic [7:0] EXC_FUNCTION = 8'h01;
    localparam logic [7:0] EXC_ADDRESS  = 8'h02;
    localparam logic [7:0] EXC_SENSOR   = 8'h04;
    localparam logic [7:0] EXC_CRC      = 8'h08;
    localparam logic [7:0] EXC_FLAG     = 8'h80;

    localparam logic [15:0] SENSOR_FAIL = 16'h00FF;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [15:0] ADDR_MAX    = 16'h00FF;
    localparam logic [15:0] BAUD_MAX    = 16'h0007;

    localparam logic [7:0] ADDR_RESET = 8'h1A;
    localparam logic [2:0] BAUD_RESET = 3'd7;

    localparam int HDR_BYTES   = 6;
    localparam int LEN_W       = 5;
    localparam int REG_W       = 3;
    localparam int JOBQ_DEPTH  = 2;
    localparam int JOBQ_PTR_W  = 1;
    localparam int JOBQ_CNT_W  = 2;

    localparam logic [7:0] MIN_FRAME = 8'd4;
    localparam logic [7:0] CNT_MAX   = 8'hFF;

    localparam logic [LEN_W-1:0] EXC_LEN      = 5'd3;
    localparam logic [LEN_W-1:0] WRITE_LEN    = 5'd6;
    localparam logic [LEN_W-1:0] READ_HDR_LEN = 5'd3;

    // Holding register map.
    localparam logic [REG_W-1:0] REG_ADDR    = 3'd0;
    localparam logic [REG_W-1:0] REG_BAUD    = 3'd1;
    localparam logic [REG_W-1:0] REG_TEMP    = 3'd2;
    localparam logic [REG_W-1:0] REG_CONST_A = 3'd3;
    localparam logic [REG_W-1:0] REG_CONST_B = 3'd4;
    localparam logic [REG_W-1:0] REG_HUMI    = 3'd5;
    localparam logic [REG_W-1:0] REG_CONST_C = 3'd6;

    localparam logic [7:0] REG_ONE = 8'h01;
    localparam logic [7:0] REG_TWO = 8'h02;

    typedef struct packed {
        logic [7:0]         request_byte;
        logic               last_byte;
        logic signed [15:0] temperature;
        logic signed [15:0] humidity;
    } request_t;

    typedef struct packed {
        logic [7:0] response_byte;
        logic       response_last;
        logic [2:0] baud_index;
    } response_t;

    // One response frame to be sent, as decided by the front end.
    typedef struct packed {
        logic                            is_read;
        logic [LEN_W-1:0]                len;
        logic [HDR_BYTES-1:0][7:0]       body;
        logic [2:0]                      baud;
        logic [15:0]                     temp;
        logic [7:0]                      humi_lo;
        logic [REG_W-1:0]                start;
    } job_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ design/rtuslv_front.sv @@
// Receive side: gathers the request header and CRC, and turns each finished frame addressed to this slave into a job.
// Depends on rtuslv_pkg.
module rtuslv_front #(
    parameter int REGISTER_COUNT = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  rtuslv_pkg::request_t request,
    output logic                 push,
    output rtuslv_pkg::job_t     job
);
    import rtuslv_pkg::*;

    localparam logic [15:0] REG_LIMIT = 16'(REGISTER_COUNT);

    logic [7:0]  own_addr_reg, own_addr_next;
    logic [2:0]  baud_reg, baud_next;
    logic [7:0]  hdr_reg [HDR_BYTES];
    logic [7:0]  hdr_next [HDR_BYTES];
    logic [7:0]  hdr_eff [HDR_BYTES];
    logic [15:0] crc_reg, crc_next, crc_upd;
    logic [7:0]  cnt_reg, cnt_next, cnt_upd;
    logic [7:0]  fn;
    logic [15:0] reg_addr, reg_val;
    logic        bad_bounds;

    always_comb
    begin
        crc_upd = crc_byte(crc_reg, request.request_byte);
        cnt_upd = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 8'd1;
        for (int i = 0; i < HDR_BYTES; i++) begin
            hdr_eff[i] = (cnt_reg == 8'(i)) ? request.request_byte : hdr_reg[i];
        end
        fn       = hdr_eff[1];
        reg_addr = {hdr_eff[2], hdr_eff[3]};
        reg_val  = {hdr_eff[4], hdr_eff[5]};
        bad_bounds = (reg_addr >= REG_LIMIT) || (reg_val == 16'd0)
                     || (reg_val > (REG_LIMIT - reg_addr));

        own_addr_next = own_addr_reg;
        baud_next     = baud_reg;
        hdr_next      = hdr_reg;
        crc_next      = crc_reg;
        cnt_next      = cnt_reg;
        push          = 1'b0;

        job.is_read = 1'b0;
        job.len     = EXC_LEN;
        job.body    = '0;
        job.body[0] = own_addr_reg;
        job.body[1] = fn ^ EXC_FLAG;
        job.body[2] = EXC_FUNCTION;
        job.baud    = baud_reg;
        job.temp    = request.temperature;
        job.humi_lo = request.humidity[7:0];
        job.start   = reg_addr[REG_W-1:0];

        if (accept) begin
            if (!request.last_byte) begin
                hdr_next = hdr_eff;
                crc_next = crc_upd;
                cnt_next = cnt_upd;
            end else begin
                for (int i = 0; i < HDR_BYTES; i++) begin
                    hdr_next[i] = 8'h00;
                end
                crc_next = CRC_INIT;
                cnt_next = 8'h00;
                push     = (hdr_eff[0] == own_addr_reg);
                if (push) begin
                    if ((cnt_upd < MIN_FRAME) || (crc_upd != 16'h0000)) begin
                        job.body[2] = EXC_CRC;
                    end else if (fn == FN_READ) begin
                        if ((request.temperature == SENSOR_FAIL)
                            || (request.humidity == SENSOR_FAIL)) begin
                            job.body[2] = EXC_SENSOR;
                        end else if (bad_bounds) begin
                            job.body[2] = EXC_ADDRESS;
                        end else begin
                            job.is_read = 1'b1;
                            job.body[1] = FN_READ;
                            job.body[2] = {reg_val[6:0], 1'b0};
                            job.len     = READ_HDR_LEN + {reg_val[3:0], 1'b0};
                        end
                    end else if (fn == FN_WRITE) begin
                        if ((reg_addr == 16'(REG_ADDR)) && (reg_val <= ADDR_MAX)) begin
                            own_addr_next = hdr_eff[5];
                            job.len       = WRITE_LEN;
                            for (int i = 0; i < HDR_BYTES; i++) begin
                                job.body[i] = hdr_eff[i];
                            end
                        end else if ((reg_addr == 16'(REG_BAUD)) && (reg_val <= BAUD_MAX)) begin
                            baud_next = hdr_eff[5][2:0];
                            job.baud  = hdr_eff[5][2:0];
                            job.len   = WRITE_LEN;
                            for (int i = 0; i < HDR_BYTES; i++) begin
                                job.body[i] = hdr_eff[i];
                            end
                        end else begin
                            job.body[2] = EXC_ADDRESS;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            own_addr_reg <= ADDR_RESET;
            baud_reg     <= BAUD_RESET;
            crc_reg      <= CRC_INIT;
            cnt_reg      <= 8'h00;
            for (int i = 0; i < HDR_BYTES; i++) begin
                hdr_reg[i] <= 8'h00;
            end
        end else begin
            own_addr_reg <= own_addr_next;
            baud_reg     <= baud_next;
            crc_reg      <= crc_next;
            cnt_reg      <= cnt_next;
            hdr_reg      <= hdr_next;
        end
    end

endmodule

@@ design/rtuslv_job_q.sv @@
// Two-entry queue of response jobs between the receive and transmit sides.
// Depends on rtuslv_pkg.
module rtuslv_job_q (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rtuslv_pkg::job_t push_job,
    input  logic             pop,
    output rtuslv_pkg::job_t head,
    output logic             empty,
    output logic             full
);
    import rtuslv_pkg::*;

    job_t                  slot_reg [JOBQ_DEPTH];
    logic [JOBQ_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [JOBQ_CNT_W-1:0] cnt_reg, cnt_next;

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == JOBQ_CNT_W'(JOBQ_DEPTH));

    always_comb
    begin
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ design/rtuslv_back.sv @@
// Transmit side: walks the job at the queue head, emitting body bytes and the frame CRC.
// Depends on rtuslv_pkg.
module rtuslv_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rtuslv_pkg::job_t      head,
    input  logic                  empty,
    output logic                  pop,
    output logic                  response_valid,
    input  logic                  response_stall,
    output rtuslv_pkg::response_t response
);
    import rtuslv_pkg::*;

    logic [LEN_W-1:0] idx_reg, idx_next, off;
    logic [15:0]      crc_reg, crc_next;
    logic             out_valid_reg;
    response_t        out_reg;
    logic             load, produce, at_crc_lo, at_crc_hi;
    logic [REG_W-1:0] reg_sel;
    logic [7:0]       reg_hi, reg_lo, body_byte, tx_byte;

    always_comb
    begin
        load      = !out_valid_reg || !response_stall;
        produce   = !empty && load;
        at_crc_lo = (idx_reg == head.len);
        at_crc_hi = (idx_reg == head.len + 1'b1);
        off       = idx_reg - READ_HDR_LEN;
        reg_sel   = head.start + off[REG_W:1];

        reg_hi = 8'h00;
        unique case (reg_sel)
            REG_ADDR:    reg_lo = head.body[0];
            REG_BAUD:    reg_lo = {5'b00000, head.baud};
            REG_TEMP:
            begin
                reg_hi = head.temp[15:8];
                reg_lo = head.temp[7:0];
            end
            REG_CONST_A: reg_lo = REG_ONE;
            REG_CONST_B: reg_lo = REG_TWO;
            REG_HUMI:    reg_lo = head.humi_lo;
            REG_CONST_C: reg_lo = REG_ONE;
            default:     reg_lo = 8'h00;
        endcase

        if (head.is_read && (idx_reg >= READ_HDR_LEN)) begin
            body_byte = off[0] ? reg_lo : reg_hi;
        end else if (idx_reg < LEN_W'(HDR_BYTES)) begin
            body_byte = head.body[idx_reg[2:0]];
        end else begin
            body_byte = 8'h00;
        end

        if (at_crc_lo) begin
            tx_byte = crc_reg[7:0];
        end else if (at_crc_hi) begin
            tx_byte = crc_reg[15:8];
        end else begin
            tx_byte = body_byte;
        end

        idx_next = idx_reg;
        crc_next = crc_reg;
        pop      = 1'b0;
        if (produce) begin
            if (at_crc_hi) begin
                idx_next = '0;
                crc_next = CRC_INIT;
                pop      = 1'b1;
            end else begin
                idx_next = idx_reg + 1'b1;
                if (!at_crc_lo) begin
                    crc_next = crc_byte(crc_reg, body_byte);
                end
            end
        end
    end

    assign response_valid = out_valid_reg;
    assign response       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= '0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            crc_reg <= crc_next;
            if (load) begin
                out_valid_reg <= produce;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce) begin
            out_reg.response_byte <= tx_byte;
            out_reg.response_last <= at_crc_hi;
            out_reg.baud_index    <= head.baud;
        end
    end

endmodule

@@ design/modbus_rtu_register_slave_core.sv @@
// Modbus RTU register slave: accepts one request byte per transfer and returns one response
// byte per transfer. The receive side takes a byte in every cycle and stalls only while both
// entries of the two-entry job queue hold frames still being sent. A frame addressed to this
// slave becomes a job in the queue once its last byte transfers, and from the queue head
// the transmit side then sends one byte per cycle, 5 to 21 bytes a frame, as the output stage
// allows. Frames for other addresses and non-final bytes produce nothing.
// Depends on rtuslv_pkg, rtuslv_front, rtuslv_job_q, rtuslv_back and assert_macros.svh.
`include "assert_macros.svh"

module modbus_rtu_register_slave_core #(
    parameter int REGISTER_COUNT = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  request_valid,
    output logic                  request_stall,
    input  rtuslv_pkg::request_t  request,
    output logic                  response_valid,
    input  logic                  response_stall,
    output rtuslv_pkg::response_t response
);
    import rtuslv_pkg::*;

    // The receive side keeps the slave address and baud selection itself, so that a write
    // frame takes effect for the very next request even while earlier replies are still
    // queued. Each job carries a snapshot of everything its reply needs.
    logic accept;
    logic q_push, q_pop, q_empty, q_full;
    job_t push_job, q_head;

    // Stalling on a full queue keeps every finished frame; a byte that is not the last
    // one would fit, but a uniform stall keeps the receive timing simple.
    assign request_stall = q_full;
    assign accept        = request_valid && !request_stall;

    rtuslv_front #(
        .REGISTER_COUNT(REGISTER_COUNT)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .request (request),
        .push    (q_push),
        .job     (push_job)
    );

    rtuslv_job_q u_job_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    // The transmit side computes the reply CRC on the fly as body bytes leave, and sends
    // its low byte first.
    rtuslv_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (q_head),
        .empty          (q_empty),
        .pop            (q_pop),
        .response_valid (response_valid),
        .response_stall (response_stall),
        .response       (response)
    );

    `RTU_ASSERT_NEVER(a_push_when_full, q_push && q_full, "job pushed into a full queue")
    `RTU_ASSERT(a_pop_ends_frame, q_pop |=> response_valid && response.response_last,
        "job retired without its final byte in the output stage")
    `RTU_ASSERT(a_read_len, (!q_empty && q_head.is_read) |-> (q_head.len[0] && (q_head.len >= 5'd5)),
        "read reply body length is not three plus a whole number of registers")

endmodule

@@ tb/sv/modbus_rtu_register_slave_core_tb.sv @@
// Self-checking testbench for the Modbus RTU register slave core: directed and random request
// frames in, every response byte compared with a transaction-level prediction of the slave.
// Depends on rtuslv_pkg and modbus_rtu_register_slave_core.
module modbus_rtu_register_slave_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtuslv_pkg::*;

    localparam int REG_COUNT    = 8;
    localparam int RANDOM_BYTES = 150;
    localparam int SETTLE_TICKS = 20;
    localparam int HOLD_TICKS   = 300;

    logic      clk            = 1'b0;
    logic      rst_n          = 1'b0;
    logic      request_valid  = 1'b0;
    logic      request_stall;
    request_t  request        = '0;
    logic      response_valid;
    logic      response_stall = 1'b0;
    response_t response;

    modbus_rtu_register_slave_core #(
        .REGISTER_COUNT(REG_COUNT)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .request       (request),
        .response_valid(response_valid),
        .response_stall(response_stall),
        .response      (response)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Traffic shaping: percentage of cycles in which each side idles, and a long hold-off
    // of the response side that is counted out in its own process.
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_active    = 1'b0;
    event hold_go;

    // Statistics and the failure count.
    int errors          = 0;
    int bytes_sent      = 0;
    int frames_sent     = 0;
    int frames_answered = 0;
    int bytes_checked   = 0;
    int input_stalls    = 0;

    // Shadow of the slave: address, baud selection and the partly received frame.
    logic [7:0]  slave_addr;
    logic [2:0]  slave_baud;
    logic [7:0]  hdr_seen [HDR_BYTES];
    logic [15:0] crc_acc;
    logic [7:0]  bytes_in;

    // Response bytes still owed by the slave, oldest first.
    response_t response_due [$];
    response_t due_head;

    // CRC-16/MODBUS, processed one bit at a time (reflected polynomial 0xA001).
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb  = acc[0] ^ data[i];
            acc = {1'b0, acc[15:1]};
            if (fb)
                acc = acc ^ CRC_POLY;
        end
        return acc;
    endfunction

    function automatic logic [15:0] frame_crc(input logic [7:0] body [$]);
        logic [15:0] crc;
        crc = CRC_INIT;
        foreach (body[k])
            crc = crc16_update(crc, body[k]);
        return crc;
    endfunction

    // Appends the CRC to a response body and queues every byte of the resulting frame.
    function automatic void queue_frame(input logic [7:0] body [$]);
        logic [15:0] crc;
        response_t   r;
        crc = frame_crc(body);
        body.push_back(crc[7:0]);
        body.push_back(crc[15:8]);
        foreach (body[k])
        begin
            r.response_byte = body[k];
            r.response_last = (k == body.size() - 1);
            r.baud_index    = slave_baud;
            response_due.push_back(r);
        end
        frames_answered++;
    endfunction

    function automatic void queue_exception(input logic [7:0] fn, input logic [7:0] code);
        logic [7:0] body [$];
        body.push_back(slave_addr);
        body.push_back(8'(fn + EXC_FLAG));
        body.push_back(code);
        queue_frame(body);
    endfunction

    function automatic logic [15:0] holding_word(input logic [REG_W-1:0] idx,
                                                 input logic [15:0] temp,
                                                 input logic [15:0] humi);
        case (idx)
            REG_ADDR:    return {8'h00, slave_addr};
            REG_BAUD:    return {13'h0, slave_baud};
            REG_TEMP:    return temp;
            REG_CONST_A: return {8'h00, REG_ONE};
            REG_CONST_B: return {8'h00, REG_TWO};
            REG_HUMI:    return {8'h00, humi[7:0]};
            REG_CONST_C: return {8'h00, REG_ONE};
            default:     return 16'h0000;
        endcase
    endfunction

    // Decides the answer to a complete frame. The readings are those carried by the last byte.
    function automatic void answer_frame(input logic [15:0] temp, input logic [15:0] humi);
        logic [7:0]  fn;
        logic [15:0] start;
        logic [15:0] qty;
        logic [15:0] word;
        logic [7:0]  body [$];
        fn    = hdr_seen[1];
        start = {hdr_seen[2], hdr_seen[3]};
        qty   = {hdr_seen[4], hdr_seen[5]};
        if (hdr_seen[0] != slave_addr)
            return;
        if (bytes_in < MIN_FRAME || crc_acc != 16'h0000)
        begin
            queue_exception(fn, EXC_CRC);
            return;
        end
        if (fn == FN_READ)
        begin
            // The sensor check takes precedence over the range check.
            if (temp == SENSOR_FAIL || humi == SENSOR_FAIL)
                queue_exception(fn, EXC_SENSOR);
            else if (start >= REG_COUNT || qty == 16'h0000
                     || int'(qty) > REG_COUNT - int'(start))
                queue_exception(fn, EXC_ADDRESS);
            else
            begin
                body.push_back(slave_addr);
                body.push_back(fn);
                body.push_back(8'(qty * 2));
                for (int k = 0; k < int'(qty); k++)
                begin
                    word = holding_word(REG_W'(int'(start) + k), temp, humi);
                    body.push_back(word[15:8]);
                    body.push_back(word[7:0]);
                end
                queue_frame(body);
            end
        end
        else if (fn == FN_WRITE)
        begin
            // The value is judged as a whole 16-bit word, never truncated.
            if (start == 16'(REG_ADDR) && qty <= ADDR_MAX)
                slave_addr = qty[7:0];
            else if (start == 16'(REG_BAUD) && qty <= BAUD_MAX)
                slave_baud = qty[2:0];
            else
            begin
                queue_exception(fn, EXC_ADDRESS);
                return;
            end
            // The echo carries the address the request was sent to, not the new one.
            for (int k = 0; k < HDR_BYTES; k++)
                body.push_back(hdr_seen[k]);
            queue_frame(body);
        end
        else
            queue_exception(fn, EXC_FUNCTION);
    endfunction

    function automatic void clear_frame();
        foreach (hdr_seen[k])
            hdr_seen[k] = 8'h00;
        crc_acc  = CRC_INIT;
        bytes_in = 8'h00;
    endfunction

    // Advances the shadow by one accepted request byte.
    function automatic void predict_request(input request_t item);
        if (bytes_in < HDR_BYTES)
            hdr_seen[bytes_in] = item.request_byte;
        if (bytes_in != CNT_MAX)
            bytes_in++;
        crc_acc = crc16_update(crc_acc, item.request_byte);
        if (item.last_byte)
        begin
            answer_frame(item.temperature, item.humidity);
            clear_frame();
            frames_sent++;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        errors++;
        if (errors <= 40)
            $display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // Long hold-off of the response side, started by the hold_go event.
    always
    begin
        @(hold_go);
        hold_active <= 1'b1;
        repeat (HOLD_TICKS) @(posedge clk);
        hold_active <= 1'b0;
    end

    // Response side: one process checks each transfer against the oldest expectation and then
    // decides whether to stall in the next cycle. Values read here are those before the edge.
    always @(posedge clk)
    begin
        if (rst_n && response_valid && !response_stall)
        begin
            if (response_due.size() == 0)
                report_mismatch("response byte with nothing expected",
                                16'(response.response_byte), 16'h0000);
            else
            begin
                due_head = response_due.pop_front();
                bytes_checked++;
                if (response.response_byte !== due_head.response_byte)
                    report_mismatch("response_byte", 16'(response.response_byte),
                                    16'(due_head.response_byte));
                if (response.response_last !== due_head.response_last)
                    report_mismatch("response_last", 16'(response.response_last),
                                    16'(due_head.response_last));
                if (response.baud_index !== due_head.baud_index)
                    report_mismatch("baud_index", 16'(response.baud_index),
                                    16'(due_head.baud_index));
            end
        end
        if (rst_n && request_valid && request_stall)
            input_stalls++;
        if (hold_active)
            response_stall <= 1'b1;
        else
            response_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Offers one request byte, after a random idle gap, and waits for its transfer.
    // Must be entered in the time step of a rising edge.
    task automatic send_request_byte(input logic [7:0] data, input logic last,
                                     input logic [15:0] temp, input logic [15:0] humi);
        request_t item;
        int       gap;
        item.request_byte = data;
        item.last_byte    = last;
        item.temperature  = temp;
        item.humidity     = humi;
        gap = 0;
        while (send_idle_pct != 0 && gap < 16 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            request_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request       <= item;
        request_valid <= 1'b1;
        @(posedge clk);
        while (request_stall)
            @(posedge clk);
        predict_request(item);
        bytes_sent++;
    endtask

    // Sensor reading: mostly random, sometimes the failure marker or a corner value.
    function automatic logic [15:0] pick_reading();
        case ($urandom_range(11))
            0:       return SENSOR_FAIL;
            1:       return 16'h8000;
            2:       return 16'h7FFF;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Sends a byte string as one frame; the readings given are those on the last byte.
    task automatic send_frame(input logic [7:0] body [$], input logic [15:0] temp,
                              input logic [15:0] humi);
        for (int k = 0; k < body.size(); k++)
        begin
            if (k == body.size() - 1)
                send_request_byte(body[k], 1'b1, temp, humi);
            else
                send_request_byte(body[k], 1'b0, 16'($urandom), 16'($urandom));
        end
    endtask

    function automatic void append_crc(ref logic [7:0] body [$]);
        logic [15:0] crc;
        crc = frame_crc(body);
        body.push_back(crc[7:0]);
        body.push_back(crc[15:8]);
    endfunction

    function automatic void build_request(ref logic [7:0] body [$], input logic [7:0] addr,
                                          input logic [7:0] fn, input logic [15:0] start,
                                          input logic [15:0] qty);
        body.delete();
        body.push_back(addr);
        body.push_back(fn);
        body.push_back(start[15:8]);
        body.push_back(start[7:0]);
        body.push_back(qty[15:8]);
        body.push_back(qty[7:0]);
    endfunction

    // One random frame. Most are well formed with random content; the rest are range errors,
    // unknown functions, corrupted or short frames, long frames and frames for other slaves.
    task automatic send_random_frame();
        logic [7:0]  body [$];
        logic [7:0]  addr;
        logic [7:0]  fn;
        logic [15:0] start;
        logic [15:0] qty;
        int          pick;
        addr  = slave_addr;
        fn    = FN_READ;
        start = 16'($urandom_range(REG_COUNT - 1));
        qty   = 16'($urandom_range(REG_COUNT - int'(start), 1));
        pick  = $urandom_range(99);
        if (pick >= 30 && pick < 40)
        begin
            case ($urandom_range(3))
                0:       qty   = 16'h0000;
                1:       qty   = 16'(REG_COUNT - int'(start) + 1);
                2:       start = 16'($urandom_range(16'hFFFF, REG_COUNT));
                default:
                begin
                    start = 16'($urandom);
                    qty   = 16'($urandom);
                end
            endcase
        end
        else if (pick >= 40 && pick < 52)
        begin
            fn    = FN_WRITE;
            start = 16'(REG_BAUD);
            case ($urandom_range(5))
                0:       qty = BAUD_MAX + 16'd1;
                1:       qty = 16'($urandom);
                default: qty = 16'($urandom_range(BAUD_MAX));
            endcase
        end
        else if (pick >= 52 && pick < 60)
        begin
            fn    = FN_WRITE;
            start = 16'(REG_ADDR);
            case ($urandom_range(5))
                0:       qty = ADDR_MAX + 16'd1;
                1:       qty = 16'($urandom);
                default: qty = 16'($urandom_range(ADDR_MAX));
            endcase
        end
        else if (pick >= 60 && pick < 65)
        begin
            fn    = FN_WRITE;
            start = 16'($urandom_range(16'hFFFF, 2));
            qty   = 16'($urandom);
        end
        else if (pick >= 65 && pick < 72)
        begin
            fn = 8'($urandom_range(255));
            if (fn == FN_READ || fn == FN_WRITE)
                fn = fn ^ EXC_FLAG;
            start = 16'($urandom);
            qty   = 16'($urandom);
        end
        else if (pick >= 92)
            addr = slave_addr ^ 8'($urandom_range(255, 1));

        build_request(body, addr, fn, start, qty);
        if (pick >= 80 && pick < 86)
        begin
            // Short frame: the address and up to two more bytes, no valid CRC possible.
            body = body[0:$urandom_range(2)];
        end
        else
        begin
            // A long frame carries extra bytes that only feed the CRC.
            if (pick >= 86 && pick < 92)
                repeat ($urandom_range(6, 1)) body.push_back(8'($urandom));
            append_crc(body);
            if (pick >= 72 && pick < 80)
                body[body.size() - 1 - $urandom_range(1)] ^= 8'($urandom_range(255, 1));
        end
        send_frame(body, pick_reading(), pick_reading());
    endtask

    task automatic test_read_all_registers();
        logic [7:0] body [$];
        build_request(body, slave_addr, FN_READ, 16'h0000, 16'(REG_COUNT));
        append_crc(body);
        send_frame(body, 16'h8000, 16'h7FFF);
    endtask

    task automatic test_write_lowest_baud();
        logic [7:0] body [$];
        build_request(body, slave_addr, FN_WRITE, 16'(REG_BAUD), 16'h0000);
        append_crc(body);
        send_frame(body, 16'h7FFF, 16'h8000);
    endtask

    // A single own-address byte is a short frame; a single foreign byte gets no answer.
    task automatic test_single_byte_frames();
        send_request_byte(slave_addr, 1'b1, 16'h0000, 16'h0000);
        send_request_byte(~slave_addr, 1'b1, 16'hFFFF, 16'hFFFF);
    endtask

    // Function 0xFF with a good CRC: the exception function byte wraps to 0x7F.
    task automatic test_wrapped_function();
        logic [7:0] body [$];
        body.push_back(slave_addr);
        body.push_back(8'hFF);
        append_crc(body);
        send_frame(body, 16'hFFFF, 16'h0000);
    endtask

    // A frame longer than 255 bytes must not let the byte counter wrap into a short frame.
    task automatic test_saturated_count();
        logic [7:0] body [$];
        build_request(body, slave_addr, FN_READ, 16'(REG_TEMP), 16'h0002);
        repeat (250) body.push_back(8'($urandom));
        append_crc(body);
        send_frame(body, 16'($urandom), 16'h1234);
    endtask

    // The response side holds off for a long stretch while short frames keep arriving, so the
    // job queue fills and the request side has to stall.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        -> hold_go;
        repeat (10) send_request_byte(slave_addr, 1'b1, 16'($urandom), 16'($urandom));
        // Withdraw the last byte so that it is not taken again while the replies drain.
        request_valid <= 1'b0;
        @(posedge clk);
        while (response_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_random_traffic();
        int target;
        target = bytes_sent + RANDOM_BYTES / 3;
        send_idle_pct  = 23;
        recv_stall_pct = 82;
        while (bytes_sent < target)
            send_random_frame();
        target = bytes_sent + RANDOM_BYTES / 3;
        send_idle_pct  = 82;
        recv_stall_pct = 23;
        while (bytes_sent < target)
            send_random_frame();
        target = bytes_sent + RANDOM_BYTES / 3;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (bytes_sent < target)
            send_random_frame();
    endtask

    initial
    begin
        slave_addr = ADDR_RESET;
        slave_baud = BAUD_RESET;
        clear_frame();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_read_all_registers();
        test_write_lowest_baud();
        test_single_byte_frames();
        test_wrapped_function();
        test_saturated_count();
        test_backpressure();
        test_random_traffic();

        // Drain: let the last responses out, then watch for stray bytes for a while.
        request_valid <= 1'b0;
        recv_stall_pct = 0;
        while (response_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);

        $display("Sent %0d request bytes in %0d frames; %0d frames answered, %0d bytes checked.",
                 bytes_sent, frames_sent, frames_answered, bytes_checked);
        $display("Request side stalled for %0d cycles; %0d mismatches.", input_stalls, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial
    begin
        #10_000_000;
        $display("Timed out with %0d response bytes still expected.", response_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
